>>> rtl/greedy_nearest_point_assigner_unit_assert.svh
// Assertion macros shared by the assigner modules.
// Each expects clk and arst_n in scope.
`ifndef GREEDY_NEAREST_POINT_ASSIGNER_UNIT_ASSERT_SVH
`define GREEDY_NEAREST_POINT_ASSIGNER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define GNPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define GNPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GNPA_ASSERT_IMP(lbl, ante, cons, msg)
`define GNPA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/gnpa_pkg.sv
`timescale 1ns / 1ps

package gnpa_pkg;

	localparam int COUNT_W    = 5;
	localparam int SLOT_W     = 4;
	localparam int IN_COORD_W = 16;
	localparam int INDEX_W    = 4;
	localparam int CHEL_W     = 2;

	localparam logic [COUNT_W-1:0] POINT_COUNT_RST = 5'd16;

	// Request codes
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PLACE = 1'b1;

	typedef struct packed {
		logic                          req_type;
		logic [SLOT_W-1:0]             point_slot;
		logic signed [IN_COORD_W-1:0]  coord_x;
		logic signed [IN_COORD_W-1:0]  coord_y;
		logic signed [IN_COORD_W-1:0]  coord_z;
		logic [CHEL_W-1:0]             chelation;
	} in_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] chosen_index;
		logic               none_free;
		logic               is_last;
	} out_item_t;

	// What a scan searches for
	typedef enum logic [1:0] {
		SCAN_FIRST,
		SCAN_NEAR_P1,
		SCAN_NEAR_MID
	} scan_mode_t;

	typedef struct packed {
		logic       load;
		logic       scan_start;
		scan_mode_t mode;
		logic       emit;
		logic       last;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} dp_sts_t;

endpackage

>>> rtl/greedy_nearest_point_assigner_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake                Payload
// in        in_valid / in_ready      in_item  (gnpa_pkg::in_item_t)
// out       out_valid / out_ready    out_item (gnpa_pkg::out_item_t)
// cfg       cfg_we                   cfg_wdata (point count)
//
// A load item gives no result.
// A place item runs one scan per chosen point; each scan reads the active
// points with a one-point-per-cycle memory read and passes them through the
// distance pipeline behind it. A stalled output holds the next scan back.
// Reset clears all marks and sets the point count to sixteen.

module greedy_nearest_point_assigner_unit #(
	parameter int MAX_POINTS = 16,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  gnpa_pkg::in_item_t           in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output gnpa_pkg::out_item_t          out_item,
	input  logic                         cfg_we,
	input  logic [gnpa_pkg::COUNT_W-1:0] cfg_wdata
);

	import gnpa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	gnpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (in_item.req_type),
		.chelation (in_item.chelation),
		.cmd       (cmd),
		.sts       (sts)
	);

	gnpa_dp #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

>>> rtl/gnpa_ram.sv
`timescale 1ns / 1ps

module gnpa_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/gnpa_ctrl.sv
`timescale 1ns / 1ps
`include "greedy_nearest_point_assigner_unit_assert.svh"

module gnpa_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [gnpa_pkg::CHEL_W-1:0] chelation,
	output gnpa_pkg::dp_cmd_t           cmd,
	input  gnpa_pkg::dp_sts_t           sts
);

	import gnpa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [CHEL_W-1:0] chel_q;
	logic [1:0]        step_q;
	logic              accept;
	logic              last_step;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign last_step = ((step_q + 2'd1) == chel_q);

	// Decode commands for the datapath
	always_comb begin
		cmd      = '0;
		cmd.mode = SCAN_FIRST;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.scan_start = 1'b1;
					end
				end
			end
			ST_SCAN: begin
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = last_step;
					if (!last_step) begin
						cmd.scan_start = 1'b1;
						cmd.mode = (step_q == 2'd0) ? SCAN_NEAR_P1 : SCAN_NEAR_MID;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Sequence the scans of one placement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chel_q  <= 2'd1;
			step_q  <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req_type == REQ_PLACE) begin
						// chelation zero acts as one
						chel_q  <= (chelation == 2'd0) ? 2'd1 : chelation;
						step_q  <= 2'd0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (last_step) begin
							state_q <= ST_IDLE;
						end else begin
							step_q  <= step_q + 2'd1;
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`GNPA_ASSERT_NXT(a_last_to_idle, cmd.emit && cmd.last, in_ready,
		"controller did not return to idle after the last result")
	`GNPA_ASSERT_IMP(a_done_in_scan, sts.scan_done, state_q == ST_SCAN,
		"scan finished while no scan was awaited")

endmodule

>>> rtl/gnpa_dp.sv
`timescale 1ns / 1ps
`include "greedy_nearest_point_assigner_unit_assert.svh"

module gnpa_dp #(
	parameter int MAX_POINTS = 16,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gnpa_pkg::in_item_t           in_item,
	input  logic                         cfg_we,
	input  logic [gnpa_pkg::COUNT_W-1:0] cfg_wdata,
	input  gnpa_pkg::dp_cmd_t            cmd,
	output gnpa_pkg::dp_sts_t            sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output gnpa_pkg::out_item_t          out_item
);

	import gnpa_pkg::*;

	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int CB         = COORD_BITS;
	localparam int TGT_W      = CB + 1;
	localparam int DIF_W      = CB + 2;
	localparam int SQ_W       = 2 * CB + 4;
	localparam int SUM_W      = SQ_W + 2;
	localparam int WORD_W     = 3 * CB;
	localparam int IN_EXT_W   = (CB > IN_COORD_W) ? CB : IN_COORD_W;
	localparam int SLOT_EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam int OIDX_EXT_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

	// Configuration and marks
	logic [COUNT_W-1:0]    point_count_q;
	logic [MAX_POINTS-1:0] taken_q;
	logic [CNT_W-1:0]      act_n;

	// Load path
	logic [IN_EXT_W-1:0]   ext_x, ext_y, ext_z;
	logic [SLOT_EXT_W-1:0] slot_ext;
	logic [IDX_W-1:0]      wr_addr;
	logic [WORD_W-1:0]     wr_word;
	logic                  slot_ok;
	logic                  ram_we;

	// Scan issue
	logic             iss_act_q;
	logic [CNT_W-1:0] iss_cnt_q;
	logic [IDX_W-1:0] rd_addr;
	logic             iss_hit;

	// Distance pipeline
	logic [WORD_W-1:0]      rd_word_s1;
	logic                   vld_s1, done_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic signed [CB-1:0]   pt_c [3];
	logic signed [DIF_W-1:0] dif_s2 [3];
	logic signed [CB-1:0]   pt_s2 [3];
	logic                   vld_s2, done_s2;
	logic [IDX_W-1:0]       idx_s2;
	logic [SQ_W-1:0]        sq_s3 [3];
	logic signed [CB-1:0]   pt_s3 [3];
	logic                   vld_s3, done_s3;
	logic [IDX_W-1:0]       idx_s3;

	// Search result and targets
	scan_mode_t              mode_q;
	logic signed [TGT_W-1:0] tgt_q [3];
	logic signed [CB-1:0]    p1_q [3];
	logic signed [CB-1:0]    best_pt_q [3];
	logic [SUM_W-1:0]        best_q;
	logic [IDX_W-1:0]        pick_q;
	logic                    found_q;
	logic [SUM_W-1:0]        sum;
	logic                    take;

	// Output register
	logic                  out_valid_q;
	out_item_t             out_item_q;
	logic [OIDX_EXT_W-1:0] pick_ext;

	// Hold the point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= POINT_COUNT_RST;
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	// Clamp the count to the table size
	assign act_n = (int'(point_count_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
	                                                  : CNT_W'(point_count_q);

	// Trim or extend incoming coordinates and the slot
	always_comb begin
		ext_x    = IN_EXT_W'($unsigned(in_item.coord_x));
		ext_y    = IN_EXT_W'($unsigned(in_item.coord_y));
		ext_z    = IN_EXT_W'($unsigned(in_item.coord_z));
		wr_word  = {ext_z[CB-1:0], ext_y[CB-1:0], ext_x[CB-1:0]};
		slot_ext = SLOT_EXT_W'(in_item.point_slot);
		wr_addr  = slot_ext[IDX_W-1:0];
		slot_ok  = int'(in_item.point_slot) < MAX_POINTS;
	end

	assign ram_we = cmd.load && slot_ok;

	gnpa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_addr),
		.wdata (wr_word),
		.raddr (rd_addr),
		.rdata (rd_word_s1)
	);

	// Clear a mark on load, set the chosen one on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
		end else begin
			if (ram_we) begin
				taken_q[wr_addr] <= 1'b0;
			end
			if (cmd.emit) begin
				taken_q[pick_q] <= 1'b1;
			end
		end
	end

	// Issue one point a cycle, then a done token
	assign rd_addr = iss_cnt_q[IDX_W-1:0];
	assign iss_hit = iss_act_q && (iss_cnt_q < act_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_act_q <= 1'b0;
			iss_cnt_q <= '0;
			vld_s1    <= 1'b0;
			done_s1   <= 1'b0;
			vld_s2    <= 1'b0;
			done_s2   <= 1'b0;
			vld_s3    <= 1'b0;
			done_s3   <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				iss_act_q <= 1'b1;
				iss_cnt_q <= '0;
			end else if (iss_act_q) begin
				if (iss_hit) begin
					iss_cnt_q <= iss_cnt_q + CNT_W'(1);
				end else begin
					iss_act_q <= 1'b0;
				end
			end
			vld_s1  <= iss_hit && !taken_q[rd_addr];
			done_s1 <= iss_act_q && !iss_hit;
			vld_s2  <= vld_s1;
			done_s2 <= done_s1;
			vld_s3  <= vld_s2;
			done_s3 <= done_s2;
		end
	end

	// Unpack the stored point
	always_comb begin
		pt_c[0] = rd_word_s1[CB-1:0];
		pt_c[1] = rd_word_s1[2*CB-1:CB];
		pt_c[2] = rd_word_s1[3*CB-1:2*CB];
	end

	// Difference to target in doubled units, then one squarer per axis
	always_ff @(posedge clk) begin
		logic signed [SQ_W-1:0] dq;
		idx_s1 <= rd_addr;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		for (int a = 0; a < 3; a++) begin
			dif_s2[a] <= DIF_W'(tgt_q[a]) - (DIF_W'(pt_c[a]) <<< 1);
			pt_s2[a]  <= pt_c[a];
			dq         = SQ_W'(dif_s2[a]);
			sq_s3[a]  <= dq * dq;
			pt_s3[a]  <= pt_s2[a];
		end
	end

	// Sum the squares and compare; SCAN_FIRST keeps the first free point
	assign sum  = SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
	assign take = vld_s3 && (!found_q || (mode_q != SCAN_FIRST && sum < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.scan_start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	// Keep the best candidate and set up the next target
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			pick_q <= '0;
			mode_q <= cmd.mode;
			unique case (cmd.mode)
				SCAN_FIRST: begin
				end
				SCAN_NEAR_P1: begin
					for (int a = 0; a < 3; a++) begin
						p1_q[a]  <= best_pt_q[a];
						tgt_q[a] <= TGT_W'(best_pt_q[a]) <<< 1;
					end
				end
				SCAN_NEAR_MID: begin
					for (int a = 0; a < 3; a++) begin
						tgt_q[a] <= TGT_W'(p1_q[a]) + TGT_W'(best_pt_q[a]);
					end
				end
				default: begin
				end
			endcase
		end else if (take) begin
			pick_q <= idx_s3;
			best_q <= sum;
			for (int a = 0; a < 3; a++) begin
				best_pt_q[a] <= pt_s3[a];
			end
		end
	end

	// Output register: load on emit, drop when taken
	assign pick_ext = OIDX_EXT_W'(pick_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_item_q.chosen_index <= pick_ext[INDEX_W-1:0];
			out_item_q.none_free    <= !found_q;
			out_item_q.is_last      <= cmd.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_item      = out_item_q;
	assign sts.scan_done = done_s3;
	assign sts.out_free  = !out_valid_q || out_ready;

	`GNPA_ASSERT_NXT(a_mark_taken, cmd.emit, taken_q[$past(pick_q)],
		"emitted point was not marked taken")
	`GNPA_ASSERT_IMP(a_pick_free, sts.scan_done && found_q, !taken_q[pick_q],
		"scan picked a point that is already taken")
	`GNPA_ASSERT_IMP(a_load_idle, cmd.load, !iss_act_q && !vld_s1 && !vld_s2 && !vld_s3,
		"point loaded while a scan was in flight")

endmodule
